### sv/mfm_pkg.sv
`timescale 1ns / 1ps

package mfm_pkg;

    localparam int MFM_COUNTER_BITS = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_STALL_PWM_LEVEL      = 3'd0;
    localparam logic [2:0] CFG_STALL_TRIP_TICKS     = 3'd1;
    localparam logic [2:0] CFG_ENCODER_TRIP_TICKS   = 3'd2;
    localparam logic [2:0] CFG_DIRECTION_TRIP_TICKS = 3'd3;
    localparam logic [2:0] CFG_SIDE_TRIP_TICKS      = 3'd4;
    localparam logic [2:0] CFG_SHORT_GRACE_TICKS    = 3'd5;
    localparam logic [2:0] CFG_LONG_GRACE_TICKS     = 3'd6;

    localparam logic [7:0]  RST_STALL_PWM_LEVEL      = 8'd90;
    localparam logic [15:0] RST_STALL_TRIP_TICKS     = 16'd200;
    localparam logic [15:0] RST_ENCODER_TRIP_TICKS   = 16'd150;
    localparam logic [15:0] RST_DIRECTION_TRIP_TICKS = 16'd50;
    localparam logic [15:0] RST_SIDE_TRIP_TICKS      = 16'd150;
    localparam logic [15:0] RST_SHORT_GRACE_TICKS    = 16'd50;
    localparam logic [15:0] RST_LONG_GRACE_TICKS     = 16'd100;

    // speed thresholds in milli-rad/s
    localparam logic [16:0] ZERO_TARGET_LIM  = 17'd10;
    localparam logic [16:0] STALL_TARGET_MIN = 17'd250;
    localparam logic [16:0] STALL_SPEED_LIM  = 17'd50;
    localparam logic [16:0] ENC_TARGET_MIN   = 17'd500;
    localparam logic [16:0] HIGH_TARGET_MIN  = 17'd800;
    localparam logic [16:0] DIR_SPEED_MIN    = 17'd200;
    localparam logic [16:0] SIDE_DIFF_MIN    = 17'd2000;
    localparam logic [16:0] SIDE_SLOW_LIM    = 17'd100;

    typedef struct packed {
        logic [7:0]  stall_pwm_level;
        logic [15:0] stall_trip_ticks;
        logic [15:0] encoder_trip_ticks;
        logic [15:0] direction_trip_ticks;
        logic [15:0] side_trip_ticks;
        logic [15:0] short_grace_ticks;
        logic [15:0] long_grace_ticks;
    } t_cfg;

    typedef struct packed {
        logic               action;
        logic [1:0]         wheel;
        logic signed [15:0] target_speed;
        logic signed [15:0] measured_speed;
        logic signed [8:0]  drive_pwm;
        logic               drive_enabled;
    } t_item;

    typedef struct packed {
        logic [9:0] fault_flags;
        logic       stall_tripped_now;
    } t_result;

    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] x;
        x = {v[15], v};
        mag16 = v[15] ? 17'(-x) : 17'(x);
    endfunction

    function automatic logic [16:0] mag17(input logic signed [16:0] v);
        logic signed [17:0] x;
        x = {v[16], v};
        mag17 = v[16] ? 17'(-x) : 17'(x);
    endfunction

    function automatic logic [8:0] mag9(input logic signed [8:0] v);
        logic signed [9:0] x;
        x = {v[8], v};
        mag9 = v[8] ? 9'(-x) : 9'(x);
    endfunction

endpackage

### sv/mfm_ifs.sv
`timescale 1ns / 1ps

interface mfm_item_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [1:0]         wheel;
    logic signed [15:0] target_speed;
    logic signed [15:0] measured_speed;
    logic signed [8:0]  drive_pwm;
    logic               drive_enabled;

    modport source (output valid, action, wheel, target_speed, measured_speed,
                    drive_pwm, drive_enabled, input ready);
    modport sink (input valid, action, wheel, target_speed, measured_speed,
                  drive_pwm, drive_enabled, output ready);
endinterface

interface mfm_result_if;
    logic       valid;
    logic       ready;
    logic [9:0] fault_flags;
    logic       stall_tripped_now;

    modport source (output valid, fault_flags, stall_tripped_now, input ready);
    modport sink (input valid, fault_flags, stall_tripped_now, output ready);
endinterface

interface mfm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/mfm_cfg_regs.sv
`timescale 1ns / 1ps

module mfm_cfg_regs
    import mfm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfm_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stall_pwm_level      <= RST_STALL_PWM_LEVEL;
            r_cfg.stall_trip_ticks     <= RST_STALL_TRIP_TICKS;
            r_cfg.encoder_trip_ticks   <= RST_ENCODER_TRIP_TICKS;
            r_cfg.direction_trip_ticks <= RST_DIRECTION_TRIP_TICKS;
            r_cfg.side_trip_ticks      <= RST_SIDE_TRIP_TICKS;
            r_cfg.short_grace_ticks    <= RST_SHORT_GRACE_TICKS;
            r_cfg.long_grace_ticks     <= RST_LONG_GRACE_TICKS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_STALL_PWM_LEVEL:      r_cfg.stall_pwm_level      <= i_cfg.data[7:0];
                CFG_STALL_TRIP_TICKS:     r_cfg.stall_trip_ticks     <= i_cfg.data;
                CFG_ENCODER_TRIP_TICKS:   r_cfg.encoder_trip_ticks   <= i_cfg.data;
                CFG_DIRECTION_TRIP_TICKS: r_cfg.direction_trip_ticks <= i_cfg.data;
                CFG_SIDE_TRIP_TICKS:      r_cfg.side_trip_ticks      <= i_cfg.data;
                CFG_SHORT_GRACE_TICKS:    r_cfg.short_grace_ticks    <= i_cfg.data;
                CFG_LONG_GRACE_TICKS:     r_cfg.long_grace_ticks     <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

### sv/mfm_core.sv
`timescale 1ns / 1ps

module mfm_core
    import mfm_pkg::*;
#(
    parameter int COUNTER_BITS = MFM_COUNTER_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int CW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    function automatic logic [COUNTER_BITS-1:0] inc(input logic [COUNTER_BITS-1:0] c);
        inc = (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [CW-1:0] ext_c(input logic [COUNTER_BITS-1:0] c);
        ext_c = CW'(c);
    endfunction

    function automatic logic [CW-1:0] ext_t(input logic [15:0] t);
        ext_t = CW'(t);
    endfunction

    logic [COUNTER_BITS-1:0] r_run   [4];
    logic [COUNTER_BITS-1:0] r_stall [4];
    logic [COUNTER_BITS-1:0] r_enc   [4];
    logic [COUNTER_BITS-1:0] r_dir   [4];
    logic [1:0]              r_sign  [4];
    logic [COUNTER_BITS-1:0] r_side  [2];
    logic signed [15:0]      r_front_speed [2];
    logic [1:0]              r_front_high;
    logic [9:0]              r_fault;

    logic [COUNTER_BITS-1:0] n_run   [4];
    logic [COUNTER_BITS-1:0] n_stall [4];
    logic [COUNTER_BITS-1:0] n_enc   [4];
    logic [COUNTER_BITS-1:0] n_dir   [4];
    logic [1:0]              n_sign  [4];
    logic [COUNTER_BITS-1:0] n_side  [2];
    logic signed [15:0]      n_front_speed [2];
    logic [1:0]              n_front_high;
    logic [9:0]              n_fault;

    logic [1:0] w_front_long;
    logic       w_tripped;

    // front wheel grace status per track
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_front_long[k] = ext_c(r_run[k]) > ext_t(i_cfg.long_grace_ticks);
        end
    end

    always_comb begin
        logic [1:0]              w;
        logic                    trk;
        logic signed [15:0]      t;
        logic signed [15:0]      s;
        logic signed [15:0]      fs;
        logic [16:0]             at;
        logic [16:0]             as_;
        logic [8:0]              ap;
        logic                    zero_tgt;
        logic                    t_pos;
        logic                    rev;
        logic [COUNTER_BITS-1:0] run_n;
        logic [COUNTER_BITS-1:0] stall_b;
        logic [COUNTER_BITS-1:0] enc_b;
        logic [COUNTER_BITS-1:0] dir_b;
        logic [COUNTER_BITS-1:0] stall_n;
        logic [COUNTER_BITS-1:0] enc_n;
        logic [COUNTER_BITS-1:0] dir_n;
        logic                    long_ok;
        logic                    stall_hit;
        logic                    enc_hit;
        logic                    dir_hit;
        logic                    stall_trip;
        logic                    enc_trip;
        logic                    dir_trip;
        logic [3:0]              wmask;
        logic signed [16:0]      diff;
        logic                    side_arm;
        logic                    side_hit;
        logic [COUNTER_BITS-1:0] side_n;

        w        = i_item.wheel;
        trk      = w[0];
        t        = i_item.target_speed;
        s        = i_item.measured_speed;
        fs       = r_front_speed[trk];
        at       = mag16(t);
        as_      = mag16(s);
        ap       = mag9(i_item.drive_pwm);
        zero_tgt = at < ZERO_TARGET_LIM;
        t_pos    = !t[15];
        rev      = (t_pos && r_sign[w] == SIGN_NEG) || (!t_pos && r_sign[w] == SIGN_POS);
        wmask    = 4'b0001 << w;

        run_n   = inc(rev ? '0 : r_run[w]);
        stall_b = rev ? '0 : r_stall[w];
        enc_b   = rev ? '0 : r_enc[w];
        dir_b   = rev ? '0 : r_dir[w];
        long_ok = ext_c(run_n) > ext_t(i_cfg.long_grace_ticks);

        stall_hit = (ext_c(run_n) > ext_t(i_cfg.short_grace_ticks)) &&
                    (at >= STALL_TARGET_MIN) &&
                    (ap >= {1'b0, i_cfg.stall_pwm_level}) && (as_ < STALL_SPEED_LIM);
        stall_n    = stall_hit ? inc(stall_b) : '0;
        stall_trip = stall_hit && (ext_c(stall_n) >= ext_t(i_cfg.stall_trip_ticks));

        enc_hit  = (at > ENC_TARGET_MIN) && (ap > {1'b0, i_cfg.stall_pwm_level}) &&
                   (s == 16'sd0);
        enc_n    = !long_ok ? enc_b : (enc_hit ? inc(enc_b) : '0);
        enc_trip = long_ok && enc_hit &&
                   (ext_c(enc_n) > ext_t(i_cfg.encoder_trip_ticks));

        // measured speed runs against the target; measured magnitude must be above 200
        dir_hit  = (at > HIGH_TARGET_MIN) && (as_ > DIR_SPEED_MIN) && (t_pos == s[15]);
        dir_n    = !long_ok ? dir_b : (dir_hit ? inc(dir_b) : '0);
        dir_trip = long_ok && dir_hit &&
                   (ext_c(dir_n) > ext_t(i_cfg.direction_trip_ticks));

        diff     = $signed({fs[15], fs}) - $signed({s[15], s});
        side_arm = r_front_high[trk] && (at > HIGH_TARGET_MIN) && w_front_long[trk] &&
                   !zero_tgt && long_ok;
        side_hit = (mag17(diff) > SIDE_DIFF_MIN) &&
                   ((mag16(fs) < SIDE_SLOW_LIM) || (as_ < SIDE_SLOW_LIM));
        side_n   = (side_arm && side_hit) ? inc(r_side[trk]) : '0;

        n_run         = r_run;
        n_stall       = r_stall;
        n_enc         = r_enc;
        n_dir         = r_dir;
        n_sign        = r_sign;
        n_side        = r_side;
        n_front_speed = r_front_speed;
        n_front_high  = r_front_high;
        n_fault       = r_fault;
        w_tripped     = 1'b0;

        if (i_item.action) begin
            for (int k = 0; k < 4; k++) begin
                n_run[k]   = '0;
                n_stall[k] = '0;
                n_enc[k]   = '0;
                n_dir[k]   = '0;
                n_sign[k]  = SIGN_NONE;
            end
            n_side[0] = '0;
            n_side[1] = '0;
            n_fault   = '0;
        end else if (i_item.drive_enabled) begin
            if (zero_tgt) begin
                n_run[w]   = '0;
                n_stall[w] = '0;
                n_enc[w]   = '0;
                n_dir[w]   = '0;
                n_sign[w]  = SIGN_NONE;
            end else begin
                n_run[w]   = run_n;
                n_stall[w] = stall_n;
                n_enc[w]   = enc_n;
                n_dir[w]   = dir_n;
                n_sign[w]  = t_pos ? SIGN_POS : SIGN_NEG;
                w_tripped  = stall_trip && !r_fault[w];
                if (stall_trip) begin
                    n_fault[3:0] = n_fault[3:0] | wmask;
                end
                if (enc_trip || dir_trip) begin
                    n_fault[7:4] = n_fault[7:4] | wmask;
                end
            end
            if (w[1]) begin
                n_side[trk] = side_n;
                if (side_arm && side_hit &&
                    (ext_c(side_n) > ext_t(i_cfg.side_trip_ticks))) begin
                    n_fault[9:8] = n_fault[9:8] | (2'b01 << trk);
                end
            end else begin
                n_front_speed[trk] = s;
                n_front_high[trk]  = at > HIGH_TARGET_MIN;
            end
        end
    end

    assign o_res.fault_flags       = n_fault;
    assign o_res.stall_tripped_now = w_tripped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_run[k]   <= '0;
                r_stall[k] <= '0;
                r_enc[k]   <= '0;
                r_dir[k]   <= '0;
                r_sign[k]  <= SIGN_NONE;
            end
            for (int k = 0; k < 2; k++) begin
                r_side[k]        <= '0;
                r_front_speed[k] <= '0;
            end
            r_front_high <= '0;
            r_fault      <= '0;
        end else if (i_fire) begin
            r_run         <= n_run;
            r_stall       <= n_stall;
            r_enc         <= n_enc;
            r_dir         <= n_dir;
            r_sign        <= n_sign;
            r_side        <= n_side;
            r_front_speed <= n_front_speed;
            r_front_high  <= n_front_high;
            r_fault       <= n_fault;
        end
    end

endmodule

### sv/motor_fault_monitor.sv
`timescale 1ns / 1ps

// Fault monitor for four motors, one wheel sample per input word.
// i_item: sample words (action, wheel, speeds, drive level, enable); wheels
//   0..3 in order per control tick; action 1 clears all faults and counters.
// o_res: one result word per input word, the fault flags after that word and
//   a flag for a stall fault newly set by it.
// i_cfg: register writes (index, data), always ready; write only while idle.
// Path: a word accepted goes into the input register, then one pass of
//   compare and counter logic carries it into the result register.
//   Throughput: one word per cycle, sustained while the receiver keeps
//   ready high.
// The per-wheel state is updated in the same pass that fills the result
//   register, so a following word sees it without a bubble.
// When the receiver stalls, the result register holds and the input register
//   takes one more word; after that ready drops until the result is taken.
// Reset (synchronous, active low): registers return to their defaults, all
//   counters, directions, side counters and fault flags are zero.
module motor_fault_monitor
    import mfm_pkg::*;
#(
    parameter int COUNTER_BITS = MFM_COUNTER_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mfm_item_if.sink     i_item,
    mfm_result_if.source o_res,
    mfm_cfg_if.sink      i_cfg
);

    t_cfg    w_cfg;
    t_item   r_item;
    t_result r_res;
    t_result w_res;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    w_adv;
    logic    w_fire;
    logic    w_take;

    mfm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    mfm_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign w_adv        = !r_out_valid || o_res.ready;
    assign w_fire       = r_in_valid && w_adv;
    assign i_item.ready = !r_in_valid || w_adv;
    assign w_take       = i_item.valid && i_item.ready;

    assign o_res.valid             = r_out_valid;
    assign o_res.fault_flags       = r_res.fault_flags;
    assign o_res.stall_tripped_now = r_res.stall_tripped_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.action         <= i_item.action;
            r_item.wheel          <= i_item.wheel;
            r_item.target_speed   <= i_item.target_speed;
            r_item.measured_speed <= i_item.measured_speed;
            r_item.drive_pwm      <= i_item.drive_pwm;
            r_item.drive_enabled  <= i_item.drive_enabled;
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

`ifndef SYNTHESIS
    // a newly tripped stall always shows in the stall flags
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.stall_tripped_now) |-> (o_res.fault_flags[3:0] != 4'd0))
        else $error("stall trip reported without a stall flag");

    // a clear word leaves no fault behind
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_item.action) |=> (r_res.fault_flags == 10'd0 && !r_res.stall_tripped_now))
        else $error("clear word left faults set");

    // clear words and disabled samples never trip a stall
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_item.action || !r_item.drive_enabled)) |-> !w_res.stall_tripped_now)
        else $error("stall trip from a word that updates nothing");

    // every processed word lands in the result register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed word has no result");
`endif

endmodule
